### src/sscf_pkg.sv
package sscf_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int FRAME_LEN    = 2 * SENSOR_COUNT + 2;
  localparam int POS_W        = $clog2(FRAME_LEN + 1);
  localparam int SEL_W        = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  localparam logic [7:0] HDR_MODE   = 8'h01;
  localparam logic [7:0] HDR_FREQ   = 8'h02;
  localparam logic [7:0] FRAME_HEAD = 8'h10;
  localparam logic [7:0] FRAME_TAIL = 8'hAA;

  localparam logic [2:0] LEN_MODE  = 3'd2;
  localparam logic [2:0] LEN_FREQ  = 3'd5;
  localparam logic [2:0] LEN_OTHER = 3'd1;

  localparam logic [31:0] FREQ_MIN_RST = 32'h3F80_0000;
  localparam logic [31:0] FREQ_MAX_RST = 32'h4282_0000;

  typedef enum logic [0:0] {
    REG_FREQ_MIN = 1'b0,
    REG_FREQ_MAX = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_EXCHANGE = 1'b0,
    OP_SENSOR   = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_MODE_SET     = 3'd1,
    EV_MODE_INVALID = 3'd2,
    EV_FREQ_SET     = 3'd3,
    EV_FREQ_IGNORED = 3'd4,
    EV_UNKNOWN_HDR  = 3'd5
  } event_t;

  // decode result handed to the telemetry side and the output register
  typedef struct packed {
    logic        arm;
    logic        mode_on;
    logic [31:0] freq_bits;
    logic        freq_changed;
    event_t      event_code;
  } dec_res_t;

endpackage

### src/sscf_decode.sv
module sscf_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 xchg_fire,
  input  logic [7:0]           rx_byte,
  output sscf_pkg::dec_res_t   res
);

  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [2:0]  expected_len_r, expected_len_nxt;
  logic [7:0]  pkt_r [4];
  logic        mode_r, mode_nxt;
  logic [31:0] freq_r, freq_nxt;
  logic [31:0] fmin_r, fmax_r;

  logic [2:0]  cnt_inc;
  logic [2:0]  exp_len;
  logic [7:0]  hdr;
  logic [31:0] bits;
  logic        done;

  always_comb begin
    cnt_inc          = byte_count_r + 3'd1;
    hdr              = (byte_count_r == 3'd0) ? rx_byte : pkt_r[0];
    bits             = {rx_byte, pkt_r[3], pkt_r[2], pkt_r[1]};
    if (byte_count_r == 3'd0) begin
      if (rx_byte == sscf_pkg::HDR_MODE)      exp_len = sscf_pkg::LEN_MODE;
      else if (rx_byte == sscf_pkg::HDR_FREQ) exp_len = sscf_pkg::LEN_FREQ;
      else                                    exp_len = sscf_pkg::LEN_OTHER;
    end else begin
      exp_len = expected_len_r;
    end
    done             = (cnt_inc >= exp_len);

    byte_count_nxt   = byte_count_r;
    expected_len_nxt = expected_len_r;
    mode_nxt         = mode_r;
    freq_nxt         = freq_r;
    res.arm          = 1'b0;
    res.freq_changed = 1'b0;
    res.event_code   = sscf_pkg::EV_NONE;

    if (xchg_fire) begin
      byte_count_nxt   = cnt_inc;
      expected_len_nxt = exp_len;
      if (done) begin
        byte_count_nxt   = 3'd0;
        expected_len_nxt = 3'd0;
        if (hdr == sscf_pkg::HDR_MODE && exp_len == sscf_pkg::LEN_MODE) begin
          res.arm = 1'b1;
          if (rx_byte <= 8'd1) begin
            mode_nxt       = rx_byte[0];
            res.event_code = sscf_pkg::EV_MODE_SET;
          end else begin
            res.event_code = sscf_pkg::EV_MODE_INVALID;
          end
        end else if (hdr == sscf_pkg::HDR_FREQ && exp_len == sscf_pkg::LEN_FREQ) begin
          res.arm = 1'b1;
          // unsigned compare of IEEE bits orders positive floats correctly
          if (bits >= fmin_r && bits < fmax_r) begin
            freq_nxt         = bits;
            res.freq_changed = 1'b1;
            res.event_code   = sscf_pkg::EV_FREQ_SET;
          end else begin
            res.event_code = sscf_pkg::EV_FREQ_IGNORED;
          end
        end else begin
          res.event_code = sscf_pkg::EV_UNKNOWN_HDR;
        end
      end
    end

    res.mode_on   = mode_nxt;
    res.freq_bits = freq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      expected_len_r <= '0;
      mode_r         <= 1'b0;
      freq_r         <= '0;
      fmin_r         <= sscf_pkg::FREQ_MIN_RST;
      fmax_r         <= sscf_pkg::FREQ_MAX_RST;
    end else begin
      byte_count_r   <= byte_count_nxt;
      expected_len_r <= expected_len_nxt;
      mode_r         <= mode_nxt;
      freq_r         <= freq_nxt;
      if (cfg_we && cfg_index == sscf_pkg::REG_FREQ_MIN) fmin_r <= cfg_wdata;
      if (cfg_we && cfg_index == sscf_pkg::REG_FREQ_MAX) fmax_r <= cfg_wdata;
    end
  end

  // the last payload byte is used straight from rx_byte, so four slots suffice
  always_ff @(posedge clk) begin
    if (xchg_fire && byte_count_r < 3'd4) begin
      pkt_r[byte_count_r[1:0]] <= rx_byte;
    end
  end

endmodule

### src/sscf_telem.sv
module sscf_telem (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                xchg_fire,
  input  logic                upd_fire,
  input  logic [2:0]          sensor_index,
  input  logic [11:0]         sensor_value,
  input  logic                arm,
  output logic [7:0]          tx_byte
);

  localparam int PW = sscf_pkg::POS_W;
  localparam int SW = sscf_pkg::SEL_W;

  logic [11:0]   sensor_r [sscf_pkg::SENSOR_COUNT];
  logic [11:0]   snap_r   [sscf_pkg::SENSOR_COUNT];
  logic [PW-1:0] pos_r, pos_nxt;
  logic          armed_r, armed_nxt;

  logic [PW-1:0] k;
  logic [11:0]   sel_val;
  logic          sending;

  always_comb begin
    k       = pos_r - PW'(1);
    sel_val = snap_r[k[SW:1]];
    sending = armed_r && (pos_r < PW'(sscf_pkg::FRAME_LEN));
    tx_byte = 8'h00;
    if (xchg_fire && sending) begin
      if (pos_r == '0)                                  tx_byte = sscf_pkg::FRAME_HEAD;
      else if (pos_r == PW'(sscf_pkg::FRAME_LEN - 1))   tx_byte = sscf_pkg::FRAME_TAIL;
      else if (!k[0])                                   tx_byte = {4'h0, sel_val[11:8]};
      else                                              tx_byte = sel_val[7:0];
    end

    pos_nxt   = pos_r;
    armed_nxt = armed_r;
    if (xchg_fire && sending) pos_nxt = pos_r + PW'(1);
    // a new arm restarts the frame after this item's byte went out
    if (xchg_fire && arm) begin
      pos_nxt   = '0;
      armed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      armed_r <= 1'b0;
      for (int i = 0; i < sscf_pkg::SENSOR_COUNT; i++) sensor_r[i] <= '0;
    end else begin
      pos_r   <= pos_nxt;
      armed_r <= armed_nxt;
      if (upd_fire && 32'(sensor_index) < 32'(sscf_pkg::SENSOR_COUNT)) begin
        sensor_r[SW'(sensor_index)] <= sensor_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xchg_fire && arm) begin
      for (int i = 0; i < sscf_pkg::SENSOR_COUNT; i++) snap_r[i] <= sensor_r[i];
    end
  end

endmodule

### src/spi_slave_command_framer_top.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_ready   | opcode, rx_byte, sensor_index, sensor_value
// out_    | output    | out_valid/out_ready | tx_byte, mode_on, freq_bits, freq_changed,
//         |           |                     | event_code
// cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One item per cycle while the output is not stalled: decode and frame lookup are done
// in the accept cycle and land in the output register, so a result shows in the cycle after its item.
// in_ready stays high while the output register is empty or being drained.
// Reset (rst_n low, synchronous) clears packet state, sensors, mode, frequency
// and restores the frequency limits to 1.0 and 65.0.
module spi_slave_command_framer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [2:0]  in_sensor_index,
  input  logic [11:0] in_sensor_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_mode_on,
  output logic [31:0] out_freq_bits,
  output logic        out_freq_changed,
  output logic [2:0]  out_event_code
);

  logic               fire, xchg_fire, upd_fire;
  sscf_pkg::dec_res_t dec;
  logic [7:0]         tx;
  logic               out_valid_r;
  logic [7:0]         tx_r;
  logic               mode_r;
  logic [31:0]        freq_r;
  logic               changed_r;
  logic [2:0]         event_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign xchg_fire = fire && (in_opcode == sscf_pkg::OP_EXCHANGE);
  assign upd_fire  = fire && (in_opcode == sscf_pkg::OP_SENSOR);

  sscf_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .xchg_fire (xchg_fire),
    .rx_byte   (in_rx_byte),
    .res       (dec)
  );

  sscf_telem u_telem (
    .clk          (clk),
    .rst_n        (rst_n),
    .xchg_fire    (xchg_fire),
    .upd_fire     (upd_fire),
    .sensor_index (in_sensor_index),
    .sensor_value (in_sensor_value),
    .arm          (dec.arm),
    .tx_byte      (tx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tx_r      <= tx;
      mode_r    <= dec.mode_on;
      freq_r    <= dec.freq_bits;
      changed_r <= dec.freq_changed;
      event_r   <= dec.event_code;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_byte      = tx_r;
  assign out_mode_on      = mode_r;
  assign out_freq_bits    = freq_r;
  assign out_freq_changed = changed_r;
  assign out_event_code   = event_r;

endmodule

### src/sscf_checker.sv
module sscf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [0:0]  cfg_index,
  input logic [31:0] cfg_wdata,
  input logic        in_valid,
  input logic        in_ready,
  input logic [0:0]  in_opcode,
  input logic [7:0]  in_rx_byte,
  input logic [2:0]  in_sensor_index,
  input logic [11:0] in_sensor_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_tx_byte,
  input logic        out_mode_on,
  input logic [31:0] out_freq_bits,
  input logic        out_freq_changed,
  input logic [2:0]  out_event_code
);

  // stalled result must not move: tx_byte, freq_bits and event_code are held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) &&
      $stable(out_freq_bits) && $stable(out_event_code))
    else $error("result changed while stalled");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free output register");

  a_changed_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_freq_changed |-> out_event_code == sscf_pkg::EV_FREQ_SET)
    else $error("frequency change without freq-set event");

endmodule

bind spi_slave_command_framer_top sscf_checker u_sscf_checker (.*);

### tb/sscf_reply_checker.sv
module sscf_reply_checker
  import sscf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [0:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [2:0]  in_sensor_index,
  input  logic [11:0] in_sensor_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_mode_on,
  input  logic [31:0] out_freq_bits,
  input  logic        out_freq_changed,
  input  logic [2:0]  out_event_code,
  output int          fail_count,
  output int          replies_owed,
  output int          replies_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        mode_on;
    logic [31:0] freq_bits;
    logic        freq_changed;
    event_t      event_code;
  } reply_t;

  reply_t      owed_q[$];
  logic [31:0] lim_lo;
  logic [31:0] lim_hi;
  logic [7:0]  pkt[5];
  logic [11:0] sensors[SENSOR_COUNT];
  logic [7:0]  frame[FRAME_LEN];
  logic        armed;
  int          frame_at;
  int          pkt_got;
  int          pkt_want;
  logic        mode_q;
  logic [31:0] freq_q;
  int          fails = 0;
  int          checked = 0;

  task automatic clear_state();
    lim_lo   = FREQ_MIN_RST;
    lim_hi   = FREQ_MAX_RST;
    armed    = 1'b0;
    frame_at = 0;
    pkt_got  = 0;
    pkt_want = 0;
    mode_q   = 1'b0;
    freq_q   = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) sensors[i] = '0;
    owed_q.delete();
  endtask

  // telemetry frame: head, each sensor as high nibble then low byte, tail
  task automatic snapshot_frame();
    frame[0] = FRAME_HEAD;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      frame[2*i+1] = {4'h0, sensors[i][11:8]};
      frame[2*i+2] = sensors[i][7:0];
    end
    frame[FRAME_LEN-1] = FRAME_TAIL;
    frame_at = 0;
    armed    = 1'b1;
  endtask

  task automatic take_item(input opcode_t op, input logic [7:0] rx,
                           input logic [2:0] idx, input logic [11:0] val);
    reply_t      r;
    logic [31:0] bits;
    r.tx_byte      = 8'h00;
    r.freq_changed = 1'b0;
    r.event_code   = EV_NONE;
    if (op == OP_SENSOR) begin
      if (int'(idx) < SENSOR_COUNT) sensors[idx] = val;
    end else begin
      // preload comes from the frame as it stood before this decode
      if (armed && frame_at < FRAME_LEN) begin
        r.tx_byte = frame[frame_at];
        frame_at++;
      end
      if (pkt_got < 5) pkt[pkt_got] = rx;
      pkt_got++;
      if (pkt_got == 1)
        pkt_want = int'((rx == HDR_MODE) ? LEN_MODE :
                        (rx == HDR_FREQ) ? LEN_FREQ : LEN_OTHER);
      if (pkt_want != 0 && pkt_got >= pkt_want) begin
        if (pkt[0] == HDR_MODE) begin
          if (pkt[1] <= 8'd1) begin
            mode_q       = pkt[1][0];
            r.event_code = EV_MODE_SET;
          end else begin
            r.event_code = EV_MODE_INVALID;
          end
          snapshot_frame();
        end else if (pkt[0] == HDR_FREQ) begin
          bits = {pkt[4], pkt[3], pkt[2], pkt[1]};
          if (bits >= lim_lo && bits < lim_hi) begin
            freq_q         = bits;
            r.freq_changed = 1'b1;
            r.event_code   = EV_FREQ_SET;
          end else begin
            r.event_code = EV_FREQ_IGNORED;
          end
          snapshot_frame();
        end else begin
          r.event_code = EV_UNKNOWN_HDR;
        end
        pkt_got  = 0;
        pkt_want = 0;
      end
    end
    r.mode_on   = mode_q;
    r.freq_bits = freq_q;
    owed_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    reply_t r;
    if (!rst_n) begin
      clear_state();
    end else begin
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == REG_FREQ_MIN) lim_lo = cfg_wdata;
        else lim_hi = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $error("reply with no item outstanding: tx_byte 0x%0h event %0d",
                 out_tx_byte, out_event_code);
          fails++;
        end else begin
          r = owed_q.pop_front();
          check_field("tx_byte", r.tx_byte, out_tx_byte);
          check_field("mode_on", r.mode_on, out_mode_on);
          check_field("freq_bits", r.freq_bits, out_freq_bits);
          check_field("freq_changed", r.freq_changed, out_freq_changed);
          check_field("event_code", r.event_code, out_event_code);
          checked++;
        end
      end
      if (in_valid && in_ready)
        take_item(opcode_t'(in_opcode), in_rx_byte, in_sensor_index, in_sensor_value);
    end
    fail_count      <= fails;
    replies_owed    <= owed_q.size();
    replies_checked <= checked;
  end

endmodule

### tb/tb.sv
module tb;
  import sscf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [0:0]  in_opcode = '0;
  logic [7:0]  in_rx_byte = '0;
  logic [2:0]  in_sensor_index = '0;
  logic [11:0] in_sensor_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_mode_on;
  logic [31:0] out_freq_bits;
  logic        out_freq_changed;
  logic [2:0]  out_event_code;
  int          fail_count;
  int          replies_owed;
  int          replies_checked;

  int          items_sent = 0;
  int          n_mode = 0;
  int          n_freq = 0;
  int          n_unknown = 0;
  int          n_sensor = 0;
  bit          steady = 1'b0;
  bit          mix_sensors = 1'b0;
  logic [31:0] freq_lo = FREQ_MIN_RST;
  logic [31:0] freq_hi = FREQ_MAX_RST;
  int unsigned cycles = 0;

  spi_slave_command_framer_top dut (.*);

  sscf_reply_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int idle_len();
    int p;
    p = $urandom_range(99);
    if (steady || p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin : sink
    int run;
    int stall;
    forever begin
      run = $urandom_range(16, 1);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic push_item(input opcode_t op, input logic [7:0] rx,
                           input logic [2:0] idx, input logic [11:0] val);
    int gap;
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_rx_byte      <= rx;
    in_sensor_index <= idx;
    in_sensor_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // unused fields carry random values so every bit still toggles
  task automatic spi_byte(input logic [7:0] rx);
    push_item(OP_EXCHANGE, rx, 3'($urandom_range(7)), 12'($urandom_range(4095)));
  endtask

  task automatic sensor_write(input logic [2:0] idx, input logic [11:0] val);
    n_sensor++;
    push_item(OP_SENSOR, 8'($urandom_range(255)), idx, val);
  endtask

  task automatic packet_byte(input logic [7:0] rx);
    if (mix_sensors && $urandom_range(7) == 0)
      sensor_write(3'($urandom_range(SENSOR_COUNT - 1)), 12'($urandom_range(4095)));
    spi_byte(rx);
  endtask

  task automatic mode_packet(input logic [7:0] m);
    n_mode++;
    spi_byte(HDR_MODE);
    packet_byte(m);
  endtask

  task automatic freq_packet(input logic [31:0] bits);
    n_freq++;
    spi_byte(HDR_FREQ);
    packet_byte(bits[7:0]);
    packet_byte(bits[15:8]);
    packet_byte(bits[23:16]);
    packet_byte(bits[31:24]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (r == REG_FREQ_MIN) freq_lo = v;
    else freq_hi = v;
  endtask

  task automatic set_limits(input logic [31:0] lo, input logic [31:0] hi);
    drain();
    write_reg(REG_FREQ_MIN, lo);
    write_reg(REG_FREQ_MAX, hi);
  endtask

  function automatic logic [7:0] mode_value();
    if ($urandom_range(99) < 70) return 8'($urandom_range(1));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] freq_value();
    int p;
    p = $urandom_range(99);
    if (p < 45 && freq_hi > freq_lo) return freq_lo + ($urandom % (freq_hi - freq_lo));
    if (p < 60) begin
      case ($urandom_range(3))
        0: return freq_lo;
        1: return freq_hi;
        2: return freq_lo - 1;
        default: return freq_hi - 1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [7:0] other_header();
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == HDR_MODE || v == HDR_FREQ);
    return v;
  endfunction

  task automatic random_traffic(input int n);
    int stop;
    int kind;
    stop = items_sent + n;
    while (items_sent < stop) begin
      kind = $urandom_range(99);
      if (kind < 32) begin
        mode_packet(mode_value());
      end else if (kind < 64) begin
        freq_packet(freq_value());
      end else if (kind < 76) begin
        n_unknown++;
        spi_byte(other_header());
      end else if (kind < 90) begin
        sensor_write(3'($urandom_range(SENSOR_COUNT - 1)), 12'($urandom_range(4095)));
      end else if (kind < 97) begin
        // raw bytes: may leave a packet half done or run a frame dry
        repeat ($urandom_range(30, 1)) spi_byte(8'($urandom_range(255)));
      end else begin
        drain();
      end
    end
  endtask

  initial begin : stimulus
    logic [31:0] a;
    logic [31:0] b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_limits(FREQ_MIN_RST, FREQ_MAX_RST);
    sensor_write(3'd0, 12'hFFF);
    sensor_write(3'd7, 12'h000);
    sensor_write(3'd5, 12'hA5C);
    mode_packet(8'h01);
    mode_packet(8'hFF);
    mode_packet(8'h00);
    freq_packet(FREQ_MIN_RST);      // lower bound is inclusive
    freq_packet(FREQ_MAX_RST);      // upper bound is exclusive
    freq_packet(FREQ_MAX_RST - 1);
    n_unknown += 2;
    spi_byte(8'h00);
    spi_byte(8'hFF);

    mix_sensors = 1'b1;
    random_traffic(250);

    set_limits(32'h0000_0000, 32'hFFFF_FFFF);
    steady = 1'b1;
    random_traffic(150);
    steady = 1'b0;
    random_traffic(100);

    set_limits(32'h0000_0000, 32'h0000_0000);
    random_traffic(120);

    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_traffic(120);

    a = $urandom;
    b = $urandom;
    if (a > b) set_limits(b, a);
    else set_limits(a, b);
    random_traffic(200);

    set_limits(FREQ_MIN_RST, FREQ_MAX_RST);
    random_traffic(160);

    drain();
    repeat (8) @(posedge clk);
    $display("stimulus: %0d items: %0d mode, %0d freq, %0d unknown-header packets,",
             items_sent, n_mode, n_freq, n_unknown);
    $display("%0d sensor writes; %0d replies checked across six frequency limit settings",
             n_sensor, replies_checked);
    if (fail_count == 0 && replies_owed == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
